### sv/pwo_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pwo_pkg
// Shared types, codes and constant tables of the wavetable oscillator bank.
// ============================================================================
package pwo_pkg;

    // Fixed build-time constants of the waveform and pitch tables.
    localparam int unsigned TABLE_SIZE  = 1024;
    localparam int unsigned TABLE_BITS  = $clog2(TABLE_SIZE);
    localparam int unsigned FS_HZ       = 48000;

    // Port field widths.
    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned NOTE_W     = 7;
    localparam int unsigned VEL_W      = 15;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned SHAPE_W    = 2;
    localparam int unsigned S_DATA_W   = 24;
    localparam int unsigned M_DATA_W   = 16;

    // Opcodes of the input item.
    localparam logic [OPCODE_W-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 2'd2;

    // Waveform selections of the shape register.
    localparam logic [SHAPE_W-1:0] SHAPE_SINE  = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_PULSE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_TRI   = 2'd2;

    // Fixed-point constants.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] A440_Q16    = 64'd28835840;
    localparam int          PEAK_Q15    = 26214;
    localparam logic [63:0] TRI_DEN     = 64'(5 * TABLE_SIZE);

    // Semitone ratios 2^(k/12) in Q8.24.
    localparam logic [63:0] SEMITONE_Q24 [12] = '{
        64'd16777216, 64'd17774841, 64'd18831788, 64'd19951585,
        64'd21137968, 64'd22394897, 64'd23726566, 64'd25137421,
        64'd26632170, 64'd28215802, 64'd29893600, 64'd31671166
    };

    typedef logic signed [SAMPLE_W-1:0] wave_t;
    typedef wave_t wave_rom_t [TABLE_SIZE];

    // Quarter-wave sine in Q15 from a truncating Q30 Horner series.
    function automatic wave_t quarter_sine(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        x  = (HALF_PI_Q30 * m) / TABLE_SIZE;
        x2 = (x * x) >> 30;
        h  = Q30_ONE - x2 / 72;
        h  = Q30_ONE - ((x2 * h) >> 30) / 42;
        h  = Q30_ONE - ((x2 * h) >> 30) / 20;
        h  = Q30_ONE - ((x2 * h) >> 30) / 6;
        s  = (x * h) >> 30;
        s  = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return wave_t'(s[15:0]);
    endfunction

    // One full-cycle sine entry, folded from the quarter wave.
    function automatic wave_t sine_entry(input int unsigned i);
        logic [63:0] u;
        logic [63:0] quad;
        logic [63:0] r;
        wave_t       s;
        u    = 64'(4 * i);
        quad = u / TABLE_SIZE;
        r    = u % TABLE_SIZE;
        if (quad == 64'd0 || quad == 64'd2)
        begin
            s = quarter_sine(r);
        end
        else
        begin
            s = quarter_sine(64'(TABLE_SIZE) - r);
        end
        return (quad >= 64'd2) ? -s : s;
    endfunction

    // One triangle entry, peak 0.8, rounded half away from zero.
    function automatic wave_t tri_entry(input int unsigned i);
        logic [63:0] n;
        logic [63:0] u;
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        n   = 64'(TABLE_SIZE);
        u   = 64'(4 * i);
        neg = 1'b0;
        if (u < n)
        begin
            mag = u;
        end
        else if (u > 3 * n)
        begin
            mag = 4 * n - u;
            neg = 1'b1;
        end
        else if (u <= 2 * n)
        begin
            mag = 2 * n - u;
        end
        else
        begin
            mag = u - 2 * n;
            neg = 1'b1;
        end
        q = (64'd262144 * mag + TRI_DEN) / (2 * TRI_DEN);
        return neg ? -wave_t'(q[15:0]) : wave_t'(q[15:0]);
    endfunction

    function automatic wave_rom_t build_sine_rom();
        wave_rom_t rom;
        for (int unsigned i = 0; i < TABLE_SIZE; i++)
        begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    function automatic wave_rom_t build_tri_rom();
        wave_rom_t rom;
        for (int unsigned i = 0; i < TABLE_SIZE; i++)
        begin
            rom[i] = tri_entry(i);
        end
        return rom;
    endfunction

endpackage

### sv/polyphonic_wavetable_oscillator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// polyphonic_wavetable_oscillator_core
// Per-note DDS bank: phase and level memories with read-modify-write,
// sine/triangle ROMs, pulse logic and a level multiplier.
// ============================================================================
//
//  Channel   Direction  Handshake          Payload
//  --------  ---------  -----------------  ----------------------------------
//  s_        in         s_tvalid/s_tready  tdata: note, velocity; tuser: opcode
//  m_        out        m_tvalid/m_tready  tdata: sample; tuser: active
//  cfg_      in         cfg_valid/ready    cfg_data: wave shape
//
//  An item's phase and level are read from the memories at acceptance; the
//  read state reads the waveform ROM and the wave state scales by the level.
//  A new item is taken in the wave state of the last one if the output is free.
//  Reset clears the per-note valid bits at once; no clearing pass is needed.
//  The output register holds a result while m_tready is low. The item taken as
//  it was loaded is still read, then waits in ST_WAVE with s_tready low.
//
module polyphonic_wavetable_oscillator_core #(
    parameter int NOTES      = 128,
    parameter int PHASE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pwo_pkg::S_DATA_W-1:0]      s_tdata,   // [6:0] note, [21:7] velocity
    input  logic [pwo_pkg::OPCODE_W-1:0]      s_tuser,   // [1:0] opcode
    // Result items.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pwo_pkg::M_DATA_W-1:0]      m_tdata,   // [15:0] sample
    output logic                              m_tuser,   // [0] active
    // Shape register write.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pwo_pkg::SHAPE_W-1:0]       cfg_data
);

    import pwo_pkg::*;

    localparam int NW = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam logic [NOTE_W:0] NOTE_LIM = (NOTE_W + 1)'(NOTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAVE = 2'd2;

    localparam wave_rom_t SINE_ROM = build_sine_rom();
    localparam wave_rom_t TRI_ROM  = build_tri_rom();

    // Per-note phase increments, worked out at elaboration.
    logic [PHASE_BITS-1:0] inc_tab [NOTES];

    genvar g;
    generate
        for (g = 0; g < NOTES; g++)
        begin : g_inc
            localparam int unsigned D = g + 51;
            localparam int unsigned O = D / 12;
            localparam int unsigned K = D % 12;
            localparam logic [63:0] F =
                (A440_Q16 * SEMITONE_Q24[K] + (64'd1 << (33 - O))) >> (34 - O);
            localparam logic [63:0] INC =
                ((F << (PHASE_BITS - 16)) + 64'(FS_HZ / 2)) / 64'(FS_HZ);
            assign inc_tab[g] = INC[PHASE_BITS-1:0];
        end
    endgenerate

    logic [1:0]            state_reg, state_next;
    logic [SHAPE_W-1:0]    shape_reg;
    logic [NOTES-1:0]      entry_vld_reg;
    logic                  out_vld_reg, out_vld_next;
    logic [SAMPLE_W-1:0]   out_sample_reg;
    logic                  out_active_reg;

    logic [OPCODE_W-1:0]   op_reg;
    logic [NOTE_W-1:0]     note_reg;
    logic [VEL_W-1:0]      vel_reg;

    logic [PHASE_BITS-1:0] phase_mem [NOTES];
    logic [VEL_W-1:0]      level_mem [NOTES];
    logic [PHASE_BITS-1:0] phase_rd_reg;
    logic [VEL_W-1:0]      level_rd_reg;
    logic                  vld_rd_reg;

    logic                  smp_en_reg;
    logic                  act_reg;
    logic [VEL_W-1:0]      lvl_reg;
    logic                  pulse_neg_reg;
    wave_t                 sine_reg;
    wave_t                 tri_reg;

    logic                  in_accept;
    logic                  out_free;
    logic [NOTE_W-1:0]     in_note;
    logic [NW-1:0]         rd_addr;
    logic [NW-1:0]         wr_addr;
    logic                  in_range;
    logic [PHASE_BITS-1:0] ph_cur;
    logic [VEL_W-1:0]      lvl_cur;
    logic [PHASE_BITS-1:0] ph_new;
    logic [VEL_W-1:0]      lvl_new;
    logic                  mem_we;
    logic [TABLE_BITS-1:0] rom_addr;
    wave_t                 wave;
    logic signed [31:0]    product;
    logic signed [31:0]    rounded;
    logic [SAMPLE_W-1:0]   sample_val;

    // Handshakes.
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = ~out_vld_reg | m_tready;
    assign s_tready  = (state_reg == ST_IDLE) || ((state_reg == ST_WAVE) && out_free);
    assign cfg_ready = 1'b1;

    assign in_note = s_tdata[NOTE_W-1:0];
    assign rd_addr = in_note[NW-1:0];
    assign wr_addr = note_reg[NW-1:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WAVE;
            end
            ST_WAVE:
            begin
                if (out_free)
                begin
                    state_next = in_accept ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shape_reg     <= SHAPE_SINE;
            entry_vld_reg <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                shape_reg <= cfg_data;
            end
            if (mem_we)
            begin
                entry_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Item capture at acceptance.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= s_tuser;
            note_reg <= in_note;
            vel_reg  <= s_tdata[NOTE_W +: VEL_W];
        end
    end

    // Phase and level memories: read at acceptance, write back in the next cycle.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            phase_rd_reg <= phase_mem[rd_addr];
            level_rd_reg <= level_mem[rd_addr];
            vld_rd_reg   <= entry_vld_reg[rd_addr];
        end
        if (mem_we)
        begin
            phase_mem[wr_addr] <= ph_new;
            level_mem[wr_addr] <= lvl_new;
        end
    end

    // Read-modify-write of the addressed note.
    always_comb
    begin
        in_range = {1'b0, note_reg} < NOTE_LIM;
        ph_cur   = vld_rd_reg ? phase_rd_reg : '0;
        lvl_cur  = vld_rd_reg ? level_rd_reg : '0;
        ph_new   = ph_cur;
        lvl_new  = lvl_cur;
        case (op_reg)
            OP_NOTE_ON:
            begin
                ph_new  = '0;
                lvl_new = vel_reg;
            end
            OP_NOTE_OFF:
            begin
                lvl_new = '0;
            end
            OP_SAMPLE:
            begin
                ph_new = ph_cur + inc_tab[wr_addr];
            end
            default:
            begin
                ph_new  = ph_cur;
                lvl_new = lvl_cur;
            end
        endcase
        mem_we   = (state_reg == ST_READ) && in_range &&
                   (op_reg inside {OP_SAMPLE, OP_NOTE_ON, OP_NOTE_OFF});
        rom_addr = ph_cur[PHASE_BITS-1 -: TABLE_BITS];
    end

    // Waveform ROM reads and per-item flags for the scaling cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            sine_reg      <= SINE_ROM[rom_addr];
            tri_reg       <= TRI_ROM[rom_addr];
            pulse_neg_reg <= ph_cur[PHASE_BITS-1];
            lvl_reg       <= lvl_cur;
            smp_en_reg    <= in_range && (op_reg == OP_SAMPLE) && (lvl_cur != '0);
            act_reg       <= in_range && (lvl_new != '0);
        end
    end

    // Waveform select and level scaling with round to nearest.
    always_comb
    begin
        case (shape_reg)
            SHAPE_PULSE:
            begin
                wave = pulse_neg_reg ? -wave_t'(PEAK_Q15) : wave_t'(PEAK_Q15);
            end
            SHAPE_TRI:
            begin
                wave = tri_reg;
            end
            default:
            begin
                wave = sine_reg;
            end
        endcase
        product    = 32'(wave) * $signed({17'd0, lvl_reg});
        rounded    = product + 32'sd16384;
        sample_val = smp_en_reg ? rounded[30:15] : '0;
    end

    // Output register.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end
        if ((state_reg == ST_WAVE) && out_free)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WAVE) && out_free)
        begin
            out_sample_reg <= sample_val;
            out_active_reg <= act_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_active_reg;

`ifndef SYNTH
    // An accepted item is always read from the memories in the next cycle.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_READ)
        else $error("accepted item did not enter the read cycle");

    // The read cycle always moves on to the scaling cycle.
    a_read_to_wave: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_WAVE)
        else $error("read cycle not followed by scaling cycle");

    // Memory write-back happens only in the read cycle.
    a_we_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_READ)
        else $error("memory write outside the read cycle");

    // A nonzero sample only comes from an active note.
    a_sample_active: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata != '0)) |-> m_tuser)
        else $error("nonzero sample on an inactive note");

    // No item is accepted while the memory read is in flight.
    a_no_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !s_tready)
        else $error("input ready during the read cycle");
`endif

endmodule
